@@ src/tam_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the tilt angle unit.
// No dependencies; used by the channel interfaces and the top level.
package tam_pkg;

  localparam int WINDOW          = 20;
  localparam int SAMPLE_BITS     = 10;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int OUT_W   = 16;
  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = ANGLE_W + $clog2(WINDOW);

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRESCALE     = 20;
  localparam int CX_W         = SAMPLE_BITS + PRESCALE + 3;
  localparam int Z_W          = 33;
  localparam int RND_SHIFT    = 30 - ANGLE_FRAC_BITS;

  localparam int DIV_K = SUM_W + 1;
  localparam int DIV_M = (2 ** DIV_K) / WINDOW;
  localparam int MUL_W = DIV_K - $clog2(WINDOW) + 1;

  typedef logic        [ANGLE_W-1:0]     angle_t;
  typedef logic        [SUM_W-1:0]       sum_t;
  typedef logic signed [CX_W-1:0]        cx_t;
  typedef logic signed [Z_W-1:0]         z_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam z_t HALF_PI_Q30 = Z_W'(64'd1686629713);
  localparam z_t RND_ADD     = Z_W'(64'd1 << (RND_SHIFT - 1));

  localparam angle_t ANG_157 = ANGLE_W'(((157 << ANGLE_FRAC_BITS) + 50) / 100);
  localparam angle_t ANG_314 = ANGLE_W'(((314 << ANGLE_FRAC_BITS) + 50) / 100);
  localparam angle_t ANG_471 = ANGLE_W'(((471 << ANGLE_FRAC_BITS) + 50) / 100);
  localparam angle_t ANG_628 = ANGLE_W'(((628 << ANGLE_FRAC_BITS) + 50) / 100);

  function automatic z_t atan_q30(input logic [STEP_W-1:0] i);
    z_t r;
    case (i)
      4'd0:    r = Z_W'(64'd843314856);
      4'd1:    r = Z_W'(64'd497837829);
      4'd2:    r = Z_W'(64'd263043836);
      4'd3:    r = Z_W'(64'd133525158);
      4'd4:    r = Z_W'(64'd67021686);
      4'd5:    r = Z_W'(64'd33543515);
      4'd6:    r = Z_W'(64'd16775850);
      4'd7:    r = Z_W'(64'd8388437);
      4'd8:    r = Z_W'(64'd4194282);
      4'd9:    r = Z_W'(64'd2097149);
      4'd10:   r = Z_W'(64'd1048575);
      4'd11:   r = Z_W'(64'd524287);
      4'd12:   r = Z_W'(64'd262143);
      4'd13:   r = Z_W'(64'd131071);
      4'd14:   r = Z_W'(64'd65535);
      default: r = Z_W'(64'd32767);
    endcase
    return r;
  endfunction

endpackage

@@ src/tam_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and angle results out.
// Depends on tam_pkg for field widths.
interface tam_in_if;
  logic                  valid;
  logic                  ready;
  tam_pkg::sample_t      accel_x;
  tam_pkg::sample_t      accel_y;
  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

interface tam_out_if;
  logic                       valid;
  logic                       ready;
  logic [tam_pkg::OUT_W-1:0]  tilt_angle;
  logic [tam_pkg::OUT_W-1:0]  average_angle;
  logic                       window_full;
  logic                       average_changed;
  modport source (output valid, output tilt_angle, output average_angle,
                  output window_full, output average_changed, input ready);
  modport sink   (input valid, input tilt_angle, input average_angle,
                  input window_full, input average_changed, output ready);
endinterface

@@ src/tilt_angle_moving_average_unit.sv @@
`timescale 1ns / 1ps
// Tilt angle unit: iterative CORDIC arctangent plus a moving average ring.
// Depends on tam_pkg and the channel interfaces in tam_if.sv.
//
// Usage:
//   in_ch carries one beat per X/Y accelerometer sample (accel_x, accel_y).
//   out_ch carries one beat per sample: tilt angle (Q3.13 radians, 0..6.28),
//   the truncated mean of the last 20 angles, a sticky flag set once the
//   ring has wrapped, and a flag that the mean changed from the last beat.
//   A new sample is taken only once the last one is through: the 16-step
//   CORDIC loop through one shared add/shift unit, then the ring update and
//   a reciprocal divide by the window length, all run for each sample.
//   in_ch.ready is high only while the sequencer is idle.
//   A single output register holds the result; while the receiver stalls,
//   the unit still takes and works the next sample and waits at the end to
//   hand it over until the held beat is taken.
//   Reset (rst_n low, synchronous) clears the ring, running sum, slot
//   pointer, window full flag, last mean and the output valid flag.
module tilt_angle_moving_average_unit (
  input  logic          clk,
  input  logic          rst_n,
  tam_in_if.sink        in_ch,
  tam_out_if.source     out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_FINISH,
    S_UPDATE,
    S_DIV,
    S_CORR
  } state_t;

  state_t                       state_r;
  tam_pkg::cx_t                 cx_r, cy_r;
  tam_pkg::z_t                  z_r;
  logic [tam_pkg::STEP_W-1:0]   step_r;
  logic                         x_neg_r, x_zero_r, y_neg_r, y_zero_r;
  tam_pkg::angle_t              angle_r;
  tam_pkg::angle_t              ring_r [tam_pkg::WINDOW];
  logic [tam_pkg::SLOT_W-1:0]   slot_r;
  tam_pkg::sum_t                sum_r;
  logic                         filled_r;
  tam_pkg::angle_t              last_avg_r;
  tam_pkg::angle_t              q_est_r;

  logic                         out_valid_r;
  logic [tam_pkg::OUT_W-1:0]    out_tilt_r, out_avg_r;
  logic                         out_full_r, out_changed_r;

  logic [tam_pkg::SAMPLE_BITS-1:0] ax, ay;
  tam_pkg::cx_t                 dx, dy;
  logic                         cy_pos;
  tam_pkg::z_t                  z_clamp, z_rnd;
  tam_pkg::angle_t              mag, angle_nxt;
  tam_pkg::sum_t                sum_nxt;
  logic [tam_pkg::SUM_W+tam_pkg::MUL_W-1:0] prod;
  tam_pkg::sum_t                rem;
  tam_pkg::angle_t              avg_nxt;
  logic                         out_free;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.tilt_angle     = out_tilt_r;
  assign out_ch.average_angle  = out_avg_r;
  assign out_ch.window_full    = out_full_r;
  assign out_ch.average_changed = out_changed_r;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    ax = in_ch.accel_x[tam_pkg::SAMPLE_BITS-1] ?
         tam_pkg::SAMPLE_BITS'(-in_ch.accel_x) : in_ch.accel_x;
    ay = in_ch.accel_y[tam_pkg::SAMPLE_BITS-1] ?
         tam_pkg::SAMPLE_BITS'(-in_ch.accel_y) : in_ch.accel_y;
  end

  // shared CORDIC add/shift unit
  always_comb begin
    dx     = cy_r >>> step_r;
    dy     = cx_r >>> step_r;
    cy_pos = !cy_r[tam_pkg::CX_W-1] && (cy_r != '0);
  end

  always_comb begin
    if (z_r[tam_pkg::Z_W-1]) begin
      z_clamp = '0;
    end else if (z_r > tam_pkg::HALF_PI_Q30) begin
      z_clamp = tam_pkg::HALF_PI_Q30;
    end else begin
      z_clamp = z_r;
    end
    z_rnd = (z_clamp + tam_pkg::RND_ADD) >>> tam_pkg::RND_SHIFT;
    mag   = x_zero_r ? '0 : tam_pkg::ANGLE_W'(z_rnd);
    if (y_zero_r) begin
      angle_nxt = (!x_neg_r && !x_zero_r) ? tam_pkg::ANG_157 : tam_pkg::ANG_471;
    end else if (!y_neg_r) begin
      angle_nxt = x_neg_r ? tam_pkg::ANG_628 - mag : mag;
    end else begin
      angle_nxt = x_neg_r ? tam_pkg::ANG_314 + mag : tam_pkg::ANG_314 - mag;
    end
  end

  always_comb begin
    sum_nxt = sum_r - tam_pkg::SUM_W'(ring_r[slot_r]) + tam_pkg::SUM_W'(angle_r);
    prod    = (tam_pkg::SUM_W + tam_pkg::MUL_W)'(sum_r) *
              (tam_pkg::SUM_W + tam_pkg::MUL_W)'(tam_pkg::DIV_M);
    rem     = sum_r - tam_pkg::SUM_W'(q_est_r * tam_pkg::SUM_W'(tam_pkg::WINDOW));
    avg_nxt = (rem >= tam_pkg::SUM_W'(tam_pkg::WINDOW)) ? q_est_r + 1'b1 : q_est_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      sum_r       <= '0;
      filled_r    <= 1'b0;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      for (int i = 0; i < tam_pkg::WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_CORR)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_neg_r  <= in_ch.accel_x[tam_pkg::SAMPLE_BITS-1];
            y_neg_r  <= in_ch.accel_y[tam_pkg::SAMPLE_BITS-1];
            x_zero_r <= (in_ch.accel_x == '0);
            y_zero_r <= (in_ch.accel_y == '0);
            cx_r     <= tam_pkg::cx_t'(ay) <<< tam_pkg::PRESCALE;
            cy_r     <= tam_pkg::cx_t'(ax) <<< tam_pkg::PRESCALE;
            z_r      <= '0;
            step_r   <= '0;
            state_r  <= S_ITER;
          end
        end
        S_ITER: begin
          if (cy_pos) begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            z_r  <= z_r + tam_pkg::atan_q30(step_r);
          end else begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            z_r  <= z_r - tam_pkg::atan_q30(step_r);
          end
          step_r <= step_r + 1'b1;
          if (step_r == tam_pkg::STEP_W'(tam_pkg::CORDIC_STEPS - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          angle_r <= angle_nxt;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          sum_r          <= sum_nxt;
          ring_r[slot_r] <= angle_r;
          if (slot_r == tam_pkg::SLOT_W'(tam_pkg::WINDOW - 1)) begin
            slot_r   <= '0;
            filled_r <= 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          q_est_r <= tam_pkg::ANGLE_W'(prod >> tam_pkg::DIV_K);
          state_r <= S_CORR;
        end
        S_CORR: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_tilt_r    <= tam_pkg::OUT_W'(angle_r);
            out_avg_r     <= tam_pkg::OUT_W'(avg_nxt);
            out_full_r    <= filled_r;
            out_changed_r <= (avg_nxt != last_avg_r);
            last_avg_r    <= avg_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready stayed high after a sample was taken");

  a_divide_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORR) |->
      ((sum_r - tam_pkg::SUM_W'(avg_nxt * tam_pkg::SUM_W'(tam_pkg::WINDOW)))
        < tam_pkg::SUM_W'(tam_pkg::WINDOW)))
    else $error("average divide left a remainder of a full window");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |=> filled_r)
    else $error("window full flag dropped");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> (angle_r <= tam_pkg::ANG_628))
    else $error("tilt angle beyond full turn");
`endif

endmodule
